@@ rtl/uhrt_pkg.sv @@
// Shared types, constants and romanization tables for the Hangul romanizing transcoder.
package uhrt_pkg;

	typedef logic [20:0] cp_t;
	typedef logic [7:0]  byte_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// One romanization segment: up to three ASCII letters, first letter in ch[0].
	typedef struct packed {
		logic [1:0]      len;
		logic [0:3][7:0] ch;
	} seg_t;

	// Pipeline and emitter state exposed for checking at the top level.
	typedef struct packed {
		logic       v4;
		logic       hang_s4;
		logic [4:0] li_s4;
		logic [4:0] vi_s4;
		logic       em_valid;
		logic [2:0] em_idx;
		logic [2:0] em_cnt;
	} bk_status_t;

	localparam cp_t   HANGUL_FIRST = 21'h00AC00;
	localparam cp_t   HANGUL_LAST  = 21'h00D7A3;
	localparam cp_t   REPLACEMENT  = 21'h00FFFD;
	localparam cp_t   MAX_1BYTE    = 21'h00007F;
	localparam cp_t   MAX_2BYTE    = 21'h0007FF;
	localparam cp_t   MAX_3BYTE    = 21'h00FFFF;
	localparam int    NUM_INITIALS = 19;
	localparam int    NUM_VOWELS   = 21;
	localparam int    NUM_FINALS   = 28;
	localparam int    SYL_PER_INITIAL = NUM_VOWELS * NUM_FINALS;
	// floor(x / 588) = (x * RECIP_588) >> 24 for every syllable offset.
	localparam logic [14:0] RECIP_588 = 15'd28533;
	localparam int          SHIFT_588 = 24;
	// floor(x / 28) = (x * RECIP_28) >> 16 for every x below 588.
	localparam logic [11:0] RECIP_28  = 12'd2341;
	localparam int          SHIFT_28  = 16;
	localparam byte_t NUL = 8'h00;

	function automatic seg_t mk_seg(logic [1:0] len, byte_t a, byte_t b, byte_t c);
		seg_t s;
		s.len = len;
		s.ch  = {a, b, c, NUL};
		return s;
	endfunction

	function automatic seg_t initial_seg(logic [4:0] i);
		case (i)
			5'd0:    return mk_seg(2'd1, "g", NUL, NUL);
			5'd1:    return mk_seg(2'd2, "k", "k", NUL);
			5'd2:    return mk_seg(2'd1, "n", NUL, NUL);
			5'd3:    return mk_seg(2'd1, "d", NUL, NUL);
			5'd4:    return mk_seg(2'd2, "t", "t", NUL);
			5'd5:    return mk_seg(2'd1, "r", NUL, NUL);
			5'd6:    return mk_seg(2'd1, "m", NUL, NUL);
			5'd7:    return mk_seg(2'd1, "b", NUL, NUL);
			5'd8:    return mk_seg(2'd2, "p", "p", NUL);
			5'd9:    return mk_seg(2'd1, "s", NUL, NUL);
			5'd10:   return mk_seg(2'd2, "s", "s", NUL);
			5'd11:   return mk_seg(2'd0, NUL, NUL, NUL);
			5'd12:   return mk_seg(2'd1, "j", NUL, NUL);
			5'd13:   return mk_seg(2'd2, "j", "j", NUL);
			5'd14:   return mk_seg(2'd2, "c", "h", NUL);
			5'd15:   return mk_seg(2'd1, "k", NUL, NUL);
			5'd16:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd17:   return mk_seg(2'd1, "p", NUL, NUL);
			5'd18:   return mk_seg(2'd1, "h", NUL, NUL);
			default: return mk_seg(2'd0, NUL, NUL, NUL);
		endcase
	endfunction

	function automatic seg_t vowel_seg(logic [4:0] i);
		case (i)
			5'd0:    return mk_seg(2'd1, "a", NUL, NUL);
			5'd1:    return mk_seg(2'd2, "a", "e", NUL);
			5'd2:    return mk_seg(2'd2, "y", "a", NUL);
			5'd3:    return mk_seg(2'd3, "y", "a", "e");
			5'd4:    return mk_seg(2'd2, "e", "o", NUL);
			5'd5:    return mk_seg(2'd1, "e", NUL, NUL);
			5'd6:    return mk_seg(2'd3, "y", "e", "o");
			5'd7:    return mk_seg(2'd2, "y", "e", NUL);
			5'd8:    return mk_seg(2'd1, "o", NUL, NUL);
			5'd9:    return mk_seg(2'd2, "w", "a", NUL);
			5'd10:   return mk_seg(2'd3, "w", "a", "e");
			5'd11:   return mk_seg(2'd2, "o", "e", NUL);
			5'd12:   return mk_seg(2'd2, "y", "o", NUL);
			5'd13:   return mk_seg(2'd1, "u", NUL, NUL);
			5'd14:   return mk_seg(2'd2, "w", "o", NUL);
			5'd15:   return mk_seg(2'd2, "w", "e", NUL);
			5'd16:   return mk_seg(2'd2, "w", "i", NUL);
			5'd17:   return mk_seg(2'd2, "y", "u", NUL);
			5'd18:   return mk_seg(2'd2, "e", "u", NUL);
			5'd19:   return mk_seg(2'd2, "y", "i", NUL);
			5'd20:   return mk_seg(2'd1, "i", NUL, NUL);
			default: return mk_seg(2'd0, NUL, NUL, NUL);
		endcase
	endfunction

	function automatic seg_t final_seg(logic [4:0] i);
		case (i)
			5'd0:    return mk_seg(2'd0, NUL, NUL, NUL);
			5'd1:    return mk_seg(2'd1, "k", NUL, NUL);
			5'd2:    return mk_seg(2'd1, "k", NUL, NUL);
			5'd3:    return mk_seg(2'd2, "k", "s", NUL);
			5'd4:    return mk_seg(2'd1, "n", NUL, NUL);
			5'd5:    return mk_seg(2'd2, "n", "j", NUL);
			5'd6:    return mk_seg(2'd2, "n", "h", NUL);
			5'd7:    return mk_seg(2'd1, "t", NUL, NUL);
			5'd8:    return mk_seg(2'd1, "l", NUL, NUL);
			5'd9:    return mk_seg(2'd2, "l", "k", NUL);
			5'd10:   return mk_seg(2'd2, "l", "m", NUL);
			5'd11:   return mk_seg(2'd2, "l", "b", NUL);
			5'd12:   return mk_seg(2'd2, "l", "s", NUL);
			5'd13:   return mk_seg(2'd2, "l", "t", NUL);
			5'd14:   return mk_seg(2'd2, "l", "p", NUL);
			5'd15:   return mk_seg(2'd2, "l", "h", NUL);
			5'd16:   return mk_seg(2'd1, "m", NUL, NUL);
			5'd17:   return mk_seg(2'd1, "p", NUL, NUL);
			5'd18:   return mk_seg(2'd2, "p", "s", NUL);
			5'd19:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd20:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd21:   return mk_seg(2'd2, "n", "g", NUL);
			5'd22:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd23:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd24:   return mk_seg(2'd1, "k", NUL, NUL);
			5'd25:   return mk_seg(2'd1, "t", NUL, NUL);
			5'd26:   return mk_seg(2'd1, "p", NUL, NUL);
			5'd27:   return mk_seg(2'd1, "t", NUL, NUL);
			default: return mk_seg(2'd0, NUL, NUL, NUL);
		endcase
	endfunction

endpackage

@@ rtl/utf8_hangul_romanizing_transcoder.sv @@
// A decoded code point passes the queue, stages s1 to s4 and the emitter before it shows.
// Throughput: one input byte per cycle while not full, one output byte per cycle on pop.
// The emitter holds each code point until all its output bytes (1 to 7) are popped,
// which sets the sustained rate; QUEUE_DEPTH code points buffer the difference.
// Reset: arst_n clears the decoder state, queue pointers and all stage valid flags at once.
module utf8_hangul_romanizing_transcoder import uhrt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic       take;
	logic       q_wr;
	cp_t        q_wdata;
	logic       q_full;
	logic       q_rd;
	cp_t        q_rdata;
	logic       q_nonempty;
	bk_status_t st;

	assign full = q_full;
	assign take = push && !q_full;

	uhrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.cp_valid (q_wr),
		.cp       (q_wdata)
	);

	uhrt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.full     (q_full),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	uhrt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_rdata),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.status     (st)
	);

	// A decoded code point never arrives while the queue is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr && q_full))
		else $error("code point written into a full queue");

	// The reciprocal divisions must give indices inside the letter tables.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st.v4 && st.hang_s4) |-> (st.li_s4 < 5'(NUM_INITIALS)) &&
			(st.vi_s4 < 5'(NUM_VOWELS)))
		else $error("syllable index out of range");

	// The emitter always points inside a non-empty run of bytes.
	a_emit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st.em_valid |-> (st.em_cnt != 3'd0) && (st.em_idx < st.em_cnt))
		else $error("emitter index outside its run");

	// The last byte of a run that is taken leaves the emitter empty unless a new run loads.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last_of_run && !st.v4) |=> empty)
		else $error("emitter kept a finished run");

endmodule

@@ rtl/uhrt_front.sv @@
// UTF-8 decoder front end: gathers lead and continuation bytes into code points.
module uhrt_front import uhrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_item_t item,
	output logic     cp_valid,
	output cp_t      cp
);

	cp_t        partial_q;
	logic [1:0] expect_q;
	logic       bad_q;

	cp_t        partial_d;
	logic [1:0] expect_d;
	logic       bad_d;
	logic       emit;
	cp_t        emit_cp;
	logic       cont_ok;
	logic       bad_n;
	cp_t        part_n;
	logic [1:0] exp_n;
	logic [7:0] b;

	always_comb begin
		b         = item.text_byte;
		partial_d = partial_q;
		expect_d  = expect_q;
		bad_d     = bad_q;
		emit      = 1'b0;
		emit_cp   = {13'd0, b};
		cont_ok   = (b[7:6] == 2'b10);
		bad_n     = bad_q | ~cont_ok;
		part_n    = (bad_q || !cont_ok) ? partial_q : {partial_q[14:0], b[5:0]};
		exp_n     = expect_q - 2'd1;
		if (expect_q == 2'd0) begin
			if (!b[7]) begin
				emit = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				partial_d = {16'd0, b[4:0]};
				expect_d  = 2'd1;
				bad_d     = 1'b0;
			end else if (b[7:4] == 4'b1110) begin
				partial_d = {17'd0, b[3:0]};
				expect_d  = 2'd2;
				bad_d     = 1'b0;
			end else if (b[7:3] == 5'b11110) begin
				partial_d = {18'd0, b[2:0]};
				expect_d  = 2'd3;
				bad_d     = 1'b0;
			end
			// A lead byte that carries the end-of-text mark opens nothing.
			if (item.end_of_text && b[7]) begin
				partial_d = '0;
				expect_d  = 2'd0;
				bad_d     = 1'b0;
			end
		end else begin
			if (exp_n == 2'd0) begin
				emit      = 1'b1;
				emit_cp   = bad_n ? REPLACEMENT : part_n;
				partial_d = '0;
				expect_d  = 2'd0;
				bad_d     = 1'b0;
			end else if (item.end_of_text) begin
				partial_d = '0;
				expect_d  = 2'd0;
				bad_d     = 1'b0;
			end else begin
				partial_d = part_n;
				expect_d  = exp_n;
				bad_d     = bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			expect_q  <= 2'd0;
			bad_q     <= 1'b0;
		end else if (take) begin
			partial_q <= partial_d;
			expect_q  <= expect_d;
			bad_q     <= bad_d;
		end
	end

	assign cp_valid = take & emit;
	assign cp       = emit_cp;

endmodule

@@ rtl/uhrt_fifo.sv @@
// Short code point queue between the decoder and the romanizing back end.
module uhrt_fifo import uhrt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cp_t  wdata,
	output logic full,
	input  logic rd,
	output cp_t  rdata,
	output logic nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cp_t           mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign rdata    = mem_q[rptr_q];
	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);

endmodule

@@ rtl/uhrt_back.sv @@
// Back end: splits Hangul syllables, UTF-8 encodes others, emits one byte per cycle on pop.
module uhrt_back import uhrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  cp_t        q_data,
	output logic       q_rd,
	output logic       empty,
	input  logic       pop,
	output out_item_t  result,
	output bk_status_t status
);

	logic v1_q, v2_q, v3_q, v4_q;
	cp_t  cp_s1, cp_s2, cp_s3, cp_s4;
	logic hang_s1, hang_s2, hang_s3, hang_s4;
	logic [13:0] off_s1, off_s2;
	logic [4:0]  li_s2, li_s3, li_s4;
	logic [9:0]  rem_s3, rem_s4;
	logic [4:0]  vi_s4;

	logic [6:0][7:0] em_buf_q;
	logic [2:0]      em_cnt_q;
	logic [2:0]      em_idx_q;
	logic            em_v_q;

	logic em_last, em_free, ld_em, ld4, ld3, ld2, ld1, r4, r3, r2, r1;

	cp_t         off_full;
	logic [28:0] prod_li;
	logic [13:0] li_mul, rem_full;
	logic [20:0] prod_vi;
	logic [9:0]  vi_mul, ti_full;
	logic [4:0]  ti;
	seg_t        seg_i, seg_v, seg_f;
	logic [2:0]  il, ivl, total;
	logic [6:0][7:0] hang_buf, utf_buf, load_buf;
	logic [2:0]  utf_cnt, load_cnt;
	logic [2:0]  kk;
	cp_t         c;

	// Handshake chain through the decomposition stages.
	assign em_last = (em_idx_q == em_cnt_q - 3'd1);
	assign em_free = !em_v_q || (pop && em_last);
	assign ld_em   = v4_q && em_free;
	assign r4      = !v4_q || em_free;
	assign ld4     = v3_q && r4;
	assign r3      = !v3_q || r4;
	assign ld3     = v2_q && r3;
	assign r2      = !v2_q || r3;
	assign ld2     = v1_q && r2;
	assign r1      = !v1_q || r2;
	assign ld1     = q_nonempty && r1;
	assign q_rd    = ld1;

	assign off_full = q_data - HANGUL_FIRST;
	assign prod_li  = off_s1 * RECIP_588;
	assign li_mul   = li_s2 * 14'(SYL_PER_INITIAL);
	assign rem_full = off_s2 - li_mul;
	assign prod_vi  = rem_s3 * RECIP_28;
	assign vi_mul   = vi_s4 * 10'(NUM_FINALS);
	assign ti_full  = rem_s4 - vi_mul;
	assign ti       = ti_full[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			v1_q <= ld1 || (v1_q && !r2);
			v2_q <= ld2 || (v2_q && !r3);
			v3_q <= ld3 || (v3_q && !r4);
			v4_q <= ld4 || (v4_q && !em_free);
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			cp_s1   <= q_data;
			hang_s1 <= (q_data >= HANGUL_FIRST) && (q_data <= HANGUL_LAST);
			off_s1  <= off_full[13:0];
		end
		if (ld2) begin
			cp_s2   <= cp_s1;
			hang_s2 <= hang_s1;
			off_s2  <= off_s1;
			li_s2   <= prod_li[SHIFT_588 +: 5];
		end
		if (ld3) begin
			cp_s3   <= cp_s2;
			hang_s3 <= hang_s2;
			li_s3   <= li_s2;
			rem_s3  <= rem_full[9:0];
		end
		if (ld4) begin
			cp_s4   <= cp_s3;
			hang_s4 <= hang_s3;
			li_s4   <= li_s3;
			rem_s4  <= rem_s3;
			vi_s4   <= prod_vi[SHIFT_28 +: 5];
		end
	end

	// Romanization: initial, vowel and final letters packed back to back.
	always_comb begin
		seg_i = initial_seg(li_s4);
		seg_v = vowel_seg(vi_s4);
		seg_f = final_seg(ti);
		il    = {1'b0, seg_i.len};
		ivl   = il + {1'b0, seg_v.len};
		total = ivl + {1'b0, seg_f.len};
		for (int k = 0; k < 7; k++) begin
			kk = 3'(k);
			if (kk < il) begin
				hang_buf[k] = seg_i.ch[kk[1:0]];
			end else if (kk < ivl) begin
				hang_buf[k] = seg_v.ch[2'(kk - il)];
			end else begin
				hang_buf[k] = seg_f.ch[2'(kk - ivl)];
			end
		end
	end

	// Standard UTF-8 encoding of a non-syllable code point.
	always_comb begin
		c       = cp_s4;
		utf_buf = '0;
		if (c <= MAX_1BYTE) begin
			utf_buf[0] = c[7:0];
			utf_cnt    = 3'd1;
		end else if (c <= MAX_2BYTE) begin
			utf_buf[0] = {3'b110, c[10:6]};
			utf_buf[1] = {2'b10, c[5:0]};
			utf_cnt    = 3'd2;
		end else if (c <= MAX_3BYTE) begin
			utf_buf[0] = {4'b1110, c[15:12]};
			utf_buf[1] = {2'b10, c[11:6]};
			utf_buf[2] = {2'b10, c[5:0]};
			utf_cnt    = 3'd3;
		end else begin
			utf_buf[0] = {5'b11110, c[20:18]};
			utf_buf[1] = {2'b10, c[17:12]};
			utf_buf[2] = {2'b10, c[11:6]};
			utf_buf[3] = {2'b10, c[5:0]};
			utf_cnt    = 3'd4;
		end
		load_buf = hang_s4 ? hang_buf : utf_buf;
		load_cnt = hang_s4 ? total : utf_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_q   <= 1'b0;
			em_idx_q <= 3'd0;
		end else if (ld_em) begin
			em_v_q   <= 1'b1;
			em_idx_q <= 3'd0;
		end else if (em_v_q && pop) begin
			if (em_last) begin
				em_v_q <= 1'b0;
			end else begin
				em_idx_q <= em_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_em) begin
			em_buf_q <= load_buf;
			em_cnt_q <= load_cnt;
		end
	end

	assign empty              = !em_v_q;
	assign result.out_byte    = em_buf_q[em_idx_q];
	assign result.last_of_run = em_last;

	assign status.v4       = v4_q;
	assign status.hang_s4  = hang_s4;
	assign status.li_s4    = li_s4;
	assign status.vi_s4    = vi_s4;
	assign status.em_valid = em_v_q;
	assign status.em_idx   = em_idx_q;
	assign status.em_cnt   = em_cnt_q;

endmodule
